### rtl/core/ppel_pkg.sv
// Shared types and constants of the per-process event limiter.
`default_nettype none
package ppel_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned PidW = 22;
  localparam int unsigned CntW = 32;
  localparam int unsigned NumCnt = 6;
  localparam int unsigned NameSpan = 16;
  localparam int unsigned MarkLen = 4;

  typedef enum logic [2:0] {
    OP_READ = 3'd0, OP_TCP = 3'd1, OP_FD = 3'd2, OP_WRITE = 3'd3,
    OP_CLONE = 3'd4, OP_RAND = 3'd5, OP_EXIT = 3'd6, OP_MEM = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ACT_IGNORED = 3'd0, ACT_COUNTED = 3'd1, ACT_KILL = 3'd2,
    ACT_FULL = 3'd3, ACT_REMOVED = 3'd4, ACT_MEMORY = 3'd5
  } act_t;

  typedef enum logic [3:0] {
    REG_READ = 4'd0, REG_TCP = 4'd1, REG_FD = 4'd2, REG_WRITE = 4'd3,
    REG_THREAD = 4'd4, REG_RAND = 4'd5, REG_MEM = 4'd6, REG_PATTERN = 4'd7
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0, ST_READ = 2'd1, ST_OUT = 2'd2
  } state_t;

  typedef logic [CntW-1:0] cnt_row_t [NumCnt];

  // lookup result handed from the tag array to the control
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             free;
    logic [SlotW-1:0] free_slot;
  } lookup_t;

  // tag array update request
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [SlotW-1:0] slot;
    logic [PidW-1:0]  pid;
  } tag_wr_t;

  function automatic logic name_has_mark(input logic [63:0] lo, input logic [63:0] hi);
    logic [127:0] nm;
    logic found;
    nm = {hi, lo};
    found = 1'b0;
    for (int s = 0; s < NameSpan - MarkLen; s++) begin
      if (nm[s*8 +: 32] == 32'h706d6f6f) found = 1'b1;
    end
    return found;
  endfunction
endpackage
`default_nettype wire

### rtl/core/per_process_event_limiter.sv
// Top level of the per-process event limiter.
// Flow: the counter row is read as a word is accepted, the decision is made in state READ
//   and the result word is held in state OUT until taken; one word is in flight at a time,
//   so the counter memory read, the read-modify-write and the output register are taken in turn.
// Reset: synchronous; clears all valid bits, used memory and restores limits.
// No clearing pass: tags and counters are read only behind a valid bit.
`default_nettype none
module per_process_event_limiter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [21:0] pid,
  input  wire logic [63:0] name_low,
  input  wire logic [63:0] name_high,
  input  wire logic signed [31:0] return_value,
  input  wire logic [7:0]  protocol,
  input  wire logic [63:0] spawn_flags,
  input  wire logic [31:0] used_mb,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       action,
  output logic             kill,
  output logic [21:0]      target_pid
);
  localparam int unsigned CW = ppel_pkg::CntW;
  localparam int unsigned RowW = ppel_pkg::NumCnt * CW;

  // configuration registers
  logic [31:0] lim [6];
  logic [31:0] memory_limit_mb;
  logic [63:0] thread_flag_pattern;
  logic [31:0] used_memory_mb;
  logic [31:0] used_memory_mb_next;

  ppel_pkg::reg_t widx;
  assign widx = ppel_pkg::reg_t'({1'b0, paddr[5:3]});
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim[0] <= 32'd10000000;
      lim[1] <= 32'd1000;
      lim[2] <= 32'd100;
      lim[3] <= 32'd100;
      lim[4] <= 32'd100;
      lim[5] <= 32'd100;
      memory_limit_mb <= 32'd1000;
      thread_flag_pattern <= 64'd4001536;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (widx)
        ppel_pkg::REG_READ:    lim[0] <= pwdata[31:0];
        ppel_pkg::REG_TCP:     lim[1] <= pwdata[31:0];
        ppel_pkg::REG_FD:      lim[2] <= pwdata[31:0];
        ppel_pkg::REG_WRITE:   lim[3] <= pwdata[31:0];
        ppel_pkg::REG_THREAD:  lim[4] <= pwdata[31:0];
        ppel_pkg::REG_RAND:    lim[5] <= pwdata[31:0];
        ppel_pkg::REG_MEM:     memory_limit_mb <= pwdata[31:0];
        ppel_pkg::REG_PATTERN: thread_flag_pattern <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      ppel_pkg::REG_READ:    prdata = {32'd0, lim[0]};
      ppel_pkg::REG_TCP:     prdata = {32'd0, lim[1]};
      ppel_pkg::REG_FD:      prdata = {32'd0, lim[2]};
      ppel_pkg::REG_WRITE:   prdata = {32'd0, lim[3]};
      ppel_pkg::REG_THREAD:  prdata = {32'd0, lim[4]};
      ppel_pkg::REG_RAND:    prdata = {32'd0, lim[5]};
      ppel_pkg::REG_MEM:     prdata = {32'd0, memory_limit_mb};
      ppel_pkg::REG_PATTERN: prdata = thread_flag_pattern;
      default:               prdata = '0;
    endcase
  end

  // held input word
  ppel_pkg::op_t r_op;
  logic [21:0] r_pid;
  logic        r_mark, r_ok;
  logic [31:0] r_rv, r_mb;

  ppel_pkg::state_t state, state_next;
  ppel_pkg::lookup_t look;
  ppel_pkg::tag_wr_t tag_wr;
  logic [RowW-1:0] row_rd, row_wr;
  logic row_we;
  logic [2:0] act_next;

  logic accept;
  assign in_ready = (state == ppel_pkg::ST_IDLE);
  assign accept = in_valid && in_ready;

  // qualification is settled at accept time from the held-stable inputs
  logic ok_in;
  always_comb begin
    case (ppel_pkg::op_t'(op))
      ppel_pkg::OP_READ, ppel_pkg::OP_FD, ppel_pkg::OP_WRITE: ok_in = !return_value[31];
      ppel_pkg::OP_TCP:   ok_in = (protocol == 8'd6);
      ppel_pkg::OP_CLONE: ok_in = (spawn_flags == thread_flag_pattern);
      default:            ok_in = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_op   <= ppel_pkg::op_t'(op);
      r_pid  <= pid;
      r_mark <= ppel_pkg::name_has_mark(name_low, name_high);
      r_ok   <= ok_in;
      r_rv   <= return_value;
      r_mb   <= used_mb;
    end
  end

  // while idle the lookup follows the offered pid, so the counter row of
  // that slot is read at the accepting edge
  logic [21:0] look_pid;
  assign look_pid = in_ready ? pid : r_pid;

  ppel_tags u_tags (
    .clk (clk), .rst (rst), .pid (look_pid), .wr (tag_wr), .look (look)
  );

  ppel_counters u_cnt (
    .clk (clk), .rd_slot (look.hit_slot), .we (row_we),
    .wr_slot (look.hit ? look.hit_slot : look.free_slot),
    .wr_data (row_wr), .rd_data (row_rd)
  );

  // kill check over the row just read
  logic over;
  always_comb begin
    over = 1'b0;
    for (int k = 0; k < ppel_pkg::NumCnt; k++) begin
      if (row_rd[k*CW +: CW] >= lim[k]) over = 1'b1;
    end
  end

  logic [2:0] cidx;
  assign cidx = (r_op > ppel_pkg::OP_RAND) ? 3'd5 : r_op;

  // decision in the read-back cycle
  always_comb begin
    act_next = ppel_pkg::ACT_IGNORED;
    tag_wr = '0;
    tag_wr.pid = r_pid;
    tag_wr.slot = look.hit ? look.hit_slot : look.free_slot;
    row_we = 1'b0;
    row_wr = row_rd;
    used_memory_mb_next = used_memory_mb;
    if (state == ppel_pkg::ST_READ) begin
      if (r_op == ppel_pkg::OP_MEM) begin
        used_memory_mb_next = r_mb;
        act_next = ppel_pkg::ACT_MEMORY;
      end else if (r_op == ppel_pkg::OP_EXIT) begin
        if (look.hit) begin
          tag_wr.clr = 1'b1;
          act_next = ppel_pkg::ACT_REMOVED;
        end
      end else if (r_mark) begin
        if (look.hit && over && used_memory_mb >= memory_limit_mb) begin
          act_next = ppel_pkg::ACT_KILL;
        end else if (r_ok) begin
          if (look.hit) begin
            row_we = 1'b1;
            row_wr[cidx*CW +: CW] = row_rd[cidx*CW +: CW] +
                                    ((r_op == ppel_pkg::OP_READ) ? r_rv : 32'd1);
            act_next = ppel_pkg::ACT_COUNTED;
          end else if (look.free) begin
            row_we = 1'b1;
            row_wr = '0;
            row_wr[cidx*CW +: CW] = 32'd1;
            tag_wr.set = 1'b1;
            act_next = ppel_pkg::ACT_COUNTED;
          end else begin
            act_next = ppel_pkg::ACT_FULL;
          end
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ppel_pkg::ST_IDLE: if (accept) state_next = ppel_pkg::ST_READ;
      ppel_pkg::ST_READ: state_next = ppel_pkg::ST_OUT;
      ppel_pkg::ST_OUT:  if (out_ready) state_next = ppel_pkg::ST_IDLE;
      default:           state_next = ppel_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppel_pkg::ST_IDLE;
      used_memory_mb <= '0;
    end else begin
      state <= state_next;
      used_memory_mb <= used_memory_mb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ppel_pkg::ST_READ) begin
      action <= act_next;
      kill <= (act_next == ppel_pkg::ACT_KILL);
      target_pid <= r_pid;
    end
  end

  assign out_valid = (state == ppel_pkg::ST_OUT);

`ifndef SYNTHESIS
  a_kill_act: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kill == (action == ppel_pkg::ACT_KILL)))
    else $error("kill flag disagrees with action");
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second word taken while busy");
  a_read_out: assert property (@(posedge clk) disable iff (rst)
    state == ppel_pkg::ST_READ |=> out_valid)
    else $error("result not presented");
  a_no_dual: assert property (@(posedge clk) disable iff (rst)
    !(tag_wr.set && tag_wr.clr))
    else $error("tag set and clear together");
`endif
endmodule
`default_nettype wire

### rtl/core/ppel_tags.sv
// Valid bits, process-ID tags and the parallel lookup.
`default_nettype none
module ppel_tags (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ppel_pkg::PidW-1:0]   pid,
  input  wire ppel_pkg::tag_wr_t           wr,
  output ppel_pkg::lookup_t                look
);
  logic [ppel_pkg::TableEntries-1:0] slot_valid;
  logic [ppel_pkg::PidW-1:0] slot_pid [ppel_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.set) begin
      slot_valid[wr.slot] <= 1'b1;
    end else if (wr.clr) begin
      slot_valid[wr.slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) slot_pid[wr.slot] <= wr.pid;
  end

  // first match and lowest free slot
  always_comb begin
    look = '0;
    for (int i = ppel_pkg::TableEntries - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_pid[i] == pid) begin
        look.hit = 1'b1;
        look.hit_slot = ppel_pkg::SlotW'(i);
      end
      if (!slot_valid[i]) begin
        look.free = 1'b1;
        look.free_slot = ppel_pkg::SlotW'(i);
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/ppel_counters.sv
// Counter memory: six 32-bit counters a slot, registered read.
`default_nettype none
module ppel_counters (
  input  wire logic                       clk,
  input  wire logic [ppel_pkg::SlotW-1:0] rd_slot,
  input  wire logic                       we,
  input  wire logic [ppel_pkg::SlotW-1:0] wr_slot,
  input  wire logic [ppel_pkg::NumCnt*ppel_pkg::CntW-1:0] wr_data,
  output logic [ppel_pkg::NumCnt*ppel_pkg::CntW-1:0]      rd_data
);
  logic [ppel_pkg::NumCnt*ppel_pkg::CntW-1:0] mem [ppel_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (we) mem[wr_slot] <= wr_data;
    rd_data <= mem[rd_slot];
  end
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the per-process event limiter.
module tb_top;
  localparam int Slots = 64;
  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] op = '0;
  logic [21:0] pid = '0;
  logic [63:0] name_low = '0, name_high = '0;
  logic signed [31:0] return_value = '0;
  logic [7:0] protocol = '0;
  logic [63:0] spawn_flags = '0;
  logic [31:0] used_mb = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] action;
  logic kill;
  logic [21:0] target_pid;

  per_process_event_limiter u_top (.*);

  always #6 clk = ~clk;

  typedef struct {
    ppel_pkg::act_t act;
    logic           kill;
    logic [21:0]    pid;
  } verdict_t;

  // predictor copy of the limits and table
  logic [31:0] lim [7];
  logic [63:0] thread_pat;
  logic        tv   [Slots];
  logic [21:0] tpid [Slots];
  logic [31:0] tcnt [Slots][6];
  logic [31:0] mem_mb;

  verdict_t verdicts [$];
  int errors = 0;
  int idle_pct = 0, stall_pct = 0;
  int hold_cycles = 0;
  int quiet = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic bit marked(input logic [63:0] lo, input logic [63:0] hi);
    logic [127:0] nm;
    nm = {hi, lo};
    for (int s = 0; s < 12; s++)
      if (nm[s*8 +: 8] == "o" && nm[s*8+8 +: 8] == "o" &&
          nm[s*8+16 +: 8] == "m" && nm[s*8+24 +: 8] == "p") return 1;
    return 0;
  endfunction

  function automatic verdict_t predict_event(
      input ppel_pkg::op_t o, input logic [21:0] p, input logic [63:0] lo,
      input logic [63:0] hi, input logic [31:0] rv, input logic [7:0] pr,
      input logic [63:0] fl, input logic [31:0] mb);
    verdict_t v;
    int hit, fr;
    bit over, ok;
    v.act = ppel_pkg::ACT_IGNORED; v.kill = 0; v.pid = p;
    hit = -1; fr = -1;
    for (int i = 0; i < Slots; i++) begin
      if (tv[i] && tpid[i] == p && hit < 0) hit = i;
      if (!tv[i] && fr < 0) fr = i;
    end
    if (o == ppel_pkg::OP_MEM) begin
      mem_mb = mb; v.act = ppel_pkg::ACT_MEMORY;
    end else if (o == ppel_pkg::OP_EXIT) begin
      if (hit >= 0) begin
        tv[hit] = 0; v.act = ppel_pkg::ACT_REMOVED;
      end
    end else if (marked(lo, hi)) begin
      over = 0;
      if (hit >= 0)
        for (int c = 0; c < 6; c++) if (tcnt[hit][c] >= lim[c]) over = 1;
      if (over && mem_mb >= lim[ppel_pkg::REG_MEM]) begin
        v.act = ppel_pkg::ACT_KILL; v.kill = 1;
      end else begin
        case (o)
          ppel_pkg::OP_READ, ppel_pkg::OP_FD, ppel_pkg::OP_WRITE: ok = !rv[31];
          ppel_pkg::OP_TCP:   ok = (pr == 8'd6);
          ppel_pkg::OP_CLONE: ok = (fl == thread_pat);
          default:            ok = 1;
        endcase
        if (ok) begin
          if (hit >= 0) begin
            tcnt[hit][o] = tcnt[hit][o] + ((o == ppel_pkg::OP_READ) ? rv : 32'd1);
            v.act = ppel_pkg::ACT_COUNTED;
          end else if (fr < 0) begin
            v.act = ppel_pkg::ACT_FULL;
          end else begin
            tv[fr] = 1; tpid[fr] = p;
            for (int c = 0; c < 6; c++) tcnt[fr][c] = '0;
            tcnt[fr][o] = 32'd1;
            v.act = ppel_pkg::ACT_COUNTED;
          end
        end
      end
    end
    return v;
  endfunction

  // sends one event word and queues its expected outcome
  task automatic send_event(input ppel_pkg::op_t o, input logic [21:0] p,
                            input logic [63:0] lo, input logic [63:0] hi,
                            input logic [31:0] rv, input logic [7:0] pr,
                            input logic [63:0] fl, input logic [31:0] mb);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    op <= o; pid <= p; name_low <= lo; name_high <= hi; return_value <= rv;
    protocol <= pr; spawn_flags <= fl; used_mb <= mb; in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    verdicts.push_back(predict_event(o, p, lo, hi, rv, pr, fl, mb));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdicts.size() == 0) report("result word with nothing expected");
      else begin
        verdict_t e;
        e = verdicts.pop_front();
        if (action !== e.act)
          report($sformatf("action %0d, expected %0d (pid %0h)", action, e.act, e.pid));
        if (kill !== e.kill) report($sformatf("kill %0b, expected %0b", kill, e.kill));
        if (target_pid !== e.pid)
          report($sformatf("target_pid %0h, expected %0h", target_pid, e.pid));
      end
    end
  end

  // receiver back-pressure; a long hold-off is counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--; out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles with work pending but no handshake or register access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) quiet = 0;
    else if (verdicts.size() != 0 || in_valid) quiet++;
    else quiet = 0;
    if (quiet >= StallLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input ppel_pkg::reg_t r, input logic [63:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 6'(r) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (r == ppel_pkg::REG_PATTERN) thread_pat = val;
    else lim[r] = val[31:0];
  endtask

  task automatic drain();
    while (verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [63:0] tag_name(input bit yes);
    logic [63:0] n;
    n = {$urandom, $urandom};
    if (yes) n[8*$urandom_range(4) +: 32] = 32'h706d6f6f;
    return n;
  endfunction

  // random word; pid drawn from a small pool so entries are hit again
  task automatic random_event(input int pool);
    ppel_pkg::op_t o;
    logic [63:0] lo, hi;
    logic [31:0] rv;
    int k;
    o = ppel_pkg::op_t'($urandom_range(7));
    k = $urandom_range(9);
    lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
    if (k < 6) lo = tag_name(1);
    else if (k < 8) begin
      hi = {$urandom, $urandom};
      hi[8*$urandom_range(4) +: 32] = 32'h706d6f6f;
    end
    rv = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
    send_event(o, 22'($urandom_range(pool - 1) | ($urandom_range(7) == 0 ? 22'h3c0000 : 0)),
               lo, hi, rv, ($urandom_range(2) != 0) ? 8'd6 : 8'($urandom),
               ($urandom_range(2) != 0) ? thread_pat : {$urandom, $urandom},
               ($urandom_range(1) != 0) ? $urandom_range(2000) : $urandom);
  endtask

  task automatic test_directed();
    logic [63:0] nm;
    nm = 64'h00000000706d6f6f;
    send_event(ppel_pkg::OP_MEM, 22'h3fffff, '0, '0, 0, 0, 0, 32'hffffffff);
    send_event(ppel_pkg::OP_READ, 22'd1, 64'hffffffffffffffff, 64'hffffffffffffffff,
               5, 6, 0, 0);
    send_event(ppel_pkg::OP_READ, 22'd1, nm, '0, 32'h7fffffff, 0, 0, 0);
    send_event(ppel_pkg::OP_READ, 22'd1, nm, '0, 32'hffffffff, 0, 0, 0);
    send_event(ppel_pkg::OP_READ, 22'd1, nm, '0, 32'h80000000, 0, 0, 0);
    send_event(ppel_pkg::OP_TCP, 22'd2, '0, 64'h706d6f6f00000000, 0, 8'd6, 0, 0);
    send_event(ppel_pkg::OP_TCP, 22'd2, '0, 64'h706d6f6f00000000, 0, 8'hff, 0, 0);
    send_event(ppel_pkg::OP_FD, 22'd3, nm << 32, '0, 0, 0, 0, 0);
    send_event(ppel_pkg::OP_WRITE, 22'd3, nm, '0, -1, 0, 0, 0);
    send_event(ppel_pkg::OP_CLONE, 22'd4, nm, '0, 0, 0, thread_pat, 0);
    send_event(ppel_pkg::OP_CLONE, 22'd4, nm, '0, 0, 0, ~thread_pat, 0);
    send_event(ppel_pkg::OP_RAND, 22'd0, nm, '0, 0, 0, 0, 0);
    // name split across halves
    send_event(ppel_pkg::OP_RAND, 22'd5, 64'h6f6f000000000000, 64'h000000000000706d,
               0, 0, 0, 0);
    send_event(ppel_pkg::OP_RAND, 22'd5, '0, 64'h706d6f6f000000, 0, 0, 0, 0);
    send_event(ppel_pkg::OP_EXIT, 22'd1, '0, '0, 0, 0, 0, 0);
    send_event(ppel_pkg::OP_EXIT, 22'd1, '0, '0, 0, 0, 0, 0);
    send_event(ppel_pkg::OP_READ, 22'd6, nm, '0, 0, 0, 0, 0);
  endtask

  task automatic test_kill();
    logic [63:0] nm;
    nm = 64'h706d6f6f;
    drain();
    write_reg(ppel_pkg::REG_RAND, 2); write_reg(ppel_pkg::REG_MEM, 500);
    send_event(ppel_pkg::OP_MEM, 0, 0, 0, 0, 0, 0, 499);
    repeat (3) send_event(ppel_pkg::OP_RAND, 22'd9, nm, '0, 0, 0, 0, 0);
    send_event(ppel_pkg::OP_MEM, 0, 0, 0, 0, 0, 0, 500);
    send_event(ppel_pkg::OP_RAND, 22'd9, nm, '0, 0, 0, 0, 0);
    send_event(ppel_pkg::OP_EXIT, 22'd9, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_table_full();
    drain();
    for (int i = 0; i < Slots + 3; i++)
      send_event(ppel_pkg::OP_RAND, 22'(100 + i), tag_name(1), '0, 0, 0, 0, 0);
    for (int i = 0; i < Slots; i += 2)
      send_event(ppel_pkg::OP_EXIT, 22'(100 + i), 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++)
      send_event(ppel_pkg::OP_FD, 22'(300 + i), tag_name(1), '0, 0, 0, 0, 0);
    for (int i = 0; i < Slots + 3; i++)
      send_event(ppel_pkg::OP_EXIT, 22'(100 + i), 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++)
      send_event(ppel_pkg::OP_EXIT, 22'(300 + i), 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 300;
    for (int i = 0; i < 20; i++) random_event(16);
  endtask

  // limits swept through several settings, extremes included
  task automatic test_random();
    logic [31:0] sets [4];
    sets = '{32'd0, 32'd3, 32'd40, 32'hffffffff};
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      for (int r = 0; r < 7; r++)
        write_reg(ppel_pkg::reg_t'(r), (ph == 7) ? 64'hffffffff : sets[$urandom_range(3)]);
      write_reg(ppel_pkg::REG_PATTERN, (ph == 3) ? 64'hffffffffffffffff :
                                       (ph == 4) ? 64'h0 : {$urandom, $urandom});
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 86; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 86; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int i = 0; i < 78; i++) random_event((ph == 5) ? 100 : 12);
    end
  endtask

  initial begin
    for (int r = 0; r < 6; r++) lim[r] = (r == 0) ? 32'd10000000 : (r == 1) ? 32'd1000 : 32'd100;
    lim[ppel_pkg::REG_MEM] = 1000; thread_pat = 64'd4001536; mem_mb = 0;
    for (int i = 0; i < Slots; i++) tv[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_kill();
    test_table_full();
    test_backpressure();
    test_random();
    idle_pct = 0; stall_pct = 0;
    drain();
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
